// ===== hdl/rfr_pkg.sv =====
// rfr_pkg: shared types and constants for the range frame receiver
// no dependencies; used by range_frame_receiver_unit

package rfr_pkg;

    // frame parser phase
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_ADDR = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_DEV_ERR  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // device error codes
    localparam logic [1:0] DEV_NONE   = 2'd0;
    localparam logic [1:0] DEV_ERR204 = 2'd1;
    localparam logic [1:0] DEV_ERR255 = 2'd2;
    localparam logic [1:0] DEV_ERR256 = 2'd3;

    // configuration register indexes
    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_END_BYTE   = 1'b1;

    // configuration reset values
    localparam logic [7:0] START_BYTE_RESET = 8'hAA;
    localparam logic [7:0] END_BYTE_RESET   = 8'hA8;

    // counters and limits
    localparam int          BODY_W    = 7;
    localparam logic [6:0]  BODY_MAX  = 7'd127;
    localparam logic [3:0]  LEN_MAX   = 4'd15;
    localparam int          ERR_LEN   = 6;
    localparam logic [6:0]  ERR_LEN_C = 7'd6;
    localparam logic [2:0]  MATCH_ALL = 3'b111;

    // ascii digits
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    // device error texts ERR204, ERR255, ERR256
    localparam logic [7:0] ERR_TEXT [3][ERR_LEN] = '{
        '{8'h45, 8'h52, 8'h52, 8'h32, 8'h30, 8'h34},
        '{8'h45, 8'h52, 8'h52, 8'h32, 8'h35, 8'h35},
        '{8'h45, 8'h52, 8'h52, 8'h32, 8'h35, 8'h36}
    };

endpackage

// ===== hdl/range_frame_receiver_unit.sv =====
// range_frame_receiver_unit: byte-serial frame receiver for a range module
// depends on rfr_pkg (phase type, status codes, error texts)
//
// Usage:
//   Bytes come in on rx_byte with rx_valid/rx_stall; one byte is taken at each
//   edge where rx_valid is high and rx_stall low. The parser hunts for the
//   start byte, skips repeats, takes the address, then command, data and
//   checksum until the end byte. Each complete frame gives one result request
//   on res_valid/res_stall with status, address, command, distance in mm,
//   device error code and data length.
//   Throughput: one byte per cycle while rx_stall is low. Each byte updates the parser
//   registers in one pass of short logic.
//   Latency: the result shows on res_valid the cycle after the end byte when
//   no earlier result waits in the output register.
//   Stall: the result register is backed by a one-entry skid register, so
//   bytes keep flowing while a result waits; rx_stall rises only while the
//   skid register holds a second result.
//   Reset: rst_n clears the parser to hunting, empties both result registers
//   and loads start byte 0xAA and end byte 0xA8.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 start byte, 1 end byte); write only while the block is idle.

module range_frame_receiver_unit #(
    parameter int DATA_MAX   = 12,
    parameter int DIST_WIDTH = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    // byte input
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    // result output
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic [7:0]  frame_address,
    output logic [7:0]  frame_command,
    output logic [23:0] distance_mm,
    output logic [1:0]  device_error,
    output logic [3:0]  data_length
);

    localparam int ExtW = (DIST_WIDTH > 24) ? DIST_WIDTH : 24;
    localparam int BW   = rfr_pkg::BODY_W;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [23:0] dist_mm;
        logic [1:0]  dev;
        logic [3:0]  len;
    } result_t;

    // configuration registers
    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;

    // parser state
    rfr_pkg::phase_t        phase_reg, phase_next;
    logic [7:0]             addr_reg, addr_next;
    logic [7:0]             cmd_reg, cmd_next;
    logic [7:0]             pend_reg, pend_next;
    logic [BW-1:0]          body_cnt_reg, body_cnt_next;
    logic [6:0]             sum_reg, sum_next;
    logic [DIST_WIDTH-1:0]  dist_reg, dist_next;
    logic                   digits_open_reg, digits_open_next;
    logic [2:0]             match_reg, match_next;

    // result registers
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    logic    accept;
    logic    push;
    logic    pop;
    result_t res_new;

    assign rx_stall = skid_valid_reg;
    assign accept   = rx_valid && !rx_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= rfr_pkg::START_BYTE_RESET;
            end_byte_reg   <= rfr_pkg::END_BYTE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfr_pkg::CFG_START_BYTE: start_byte_reg <= cfg_data;
                rfr_pkg::CFG_END_BYTE:   end_byte_reg   <= cfg_data;
                default:                 start_byte_reg <= start_byte_reg;
            endcase
        end
    end

    // frame end detection
    logic frame_end;
    logic frame_done;
    assign frame_end  = accept && (phase_reg == rfr_pkg::PH_BODY) && (rx_byte == end_byte_reg);
    assign frame_done = frame_end && (body_cnt_reg >= BW'(2));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                rfr_pkg::PH_ADDR:
                begin
                    if (rx_byte != start_byte_reg)
                        phase_next = rfr_pkg::PH_BODY;
                end
                rfr_pkg::PH_BODY:
                begin
                    if (rx_byte == end_byte_reg)
                        phase_next = rfr_pkg::PH_HUNT;
                end
                default:
                begin
                    if (rx_byte == start_byte_reg)
                        phase_next = rfr_pkg::PH_ADDR;
                    else
                        phase_next = rfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // data byte decode for the pending byte
    logic [BW-1:0]         data_idx;
    logic                  is_digit;
    logic [DIST_WIDTH+3:0] dist_prod;
    logic [DIST_WIDTH-1:0] dist_step;
    logic [2:0]            match_step;

    assign data_idx = body_cnt_reg - BW'(2);
    assign is_digit = (pend_reg >= rfr_pkg::DIGIT_ZERO) && (pend_reg <= rfr_pkg::DIGIT_NINE);

    // acc * 10 + digit by shifts, saturating
    always_comb
    begin
        dist_prod = ({4'b0, dist_reg} << 3) + ({4'b0, dist_reg} << 1)
                  + (DIST_WIDTH+4)'(pend_reg - rfr_pkg::DIGIT_ZERO);
        if (dist_prod[DIST_WIDTH+3:DIST_WIDTH] != 4'd0)
            dist_step = '1;
        else
            dist_step = dist_prod[DIST_WIDTH-1:0];
    end

    // error text candidate match
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (data_idx < rfr_pkg::ERR_LEN_C)
                match_step[c] = match_reg[c]
                    && (rfr_pkg::ERR_TEXT[c][data_idx[2:0]] == pend_reg);
            else
                match_step[c] = 1'b0;
        end
    end

    // parser datapath
    always_comb
    begin
        addr_next        = addr_reg;
        cmd_next         = cmd_reg;
        pend_next        = pend_reg;
        body_cnt_next    = body_cnt_reg;
        sum_next         = sum_reg;
        dist_next        = dist_reg;
        digits_open_next = digits_open_reg;
        match_next       = match_reg;
        if (accept && (phase_reg == rfr_pkg::PH_ADDR) && (rx_byte != start_byte_reg))
        begin
            // open a new frame
            addr_next        = rx_byte;
            cmd_next         = 8'd0;
            pend_next        = 8'd0;
            body_cnt_next    = '0;
            sum_next         = rx_byte[6:0];
            dist_next        = '0;
            digits_open_next = 1'b1;
            match_next       = rfr_pkg::MATCH_ALL;
        end
        else if (accept && (phase_reg == rfr_pkg::PH_BODY) && (rx_byte != end_byte_reg))
        begin
            // commit the previous body byte and hold the new one
            if (body_cnt_reg != '0)
            begin
                sum_next = sum_reg + pend_reg[6:0];
                if (body_cnt_reg == BW'(1))
                    cmd_next = pend_reg;
                else
                begin
                    if (digits_open_reg && is_digit)
                        dist_next = dist_step;
                    else
                        digits_open_next = 1'b0;
                    match_next = match_step;
                end
            end
            pend_next = rx_byte;
            if (body_cnt_reg < rfr_pkg::BODY_MAX)
                body_cnt_next = body_cnt_reg + BW'(1);
        end
    end

    // result assembly at the end byte
    logic [BW-1:0]   n_data;
    logic [1:0]      dev_code;
    logic [ExtW-1:0] dist_ext;

    assign n_data = body_cnt_reg - BW'(2);

    always_comb
    begin
        dev_code = rfr_pkg::DEV_NONE;
        if (n_data == rfr_pkg::ERR_LEN_C)
        begin
            if (match_reg[0])
                dev_code = rfr_pkg::DEV_ERR204;
            else if (match_reg[1])
                dev_code = rfr_pkg::DEV_ERR255;
            else if (match_reg[2])
                dev_code = rfr_pkg::DEV_ERR256;
        end
    end

    always_comb
    begin
        dist_ext = ExtW'(dist_reg);
        res_new.addr    = addr_reg;
        res_new.cmd     = cmd_reg;
        res_new.dev     = dev_code;
        res_new.dist_mm = (dev_code != rfr_pkg::DEV_NONE) ? 24'd0 : dist_ext[23:0];
        res_new.len     = (n_data > BW'(rfr_pkg::LEN_MAX)) ? rfr_pkg::LEN_MAX : n_data[3:0];
        if (n_data > BW'(DATA_MAX))
            res_new.status = rfr_pkg::ST_TOO_LONG;
        else if (pend_reg != {1'b0, sum_reg})
            res_new.status = rfr_pkg::ST_CHECKSUM;
        else if (dev_code != rfr_pkg::DEV_NONE)
            res_new.status = rfr_pkg::ST_DEV_ERR;
        else
            res_new.status = rfr_pkg::ST_OK;
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= rfr_pkg::PH_HUNT;
            addr_reg        <= 8'd0;
            cmd_reg         <= 8'd0;
            pend_reg        <= 8'd0;
            body_cnt_reg    <= '0;
            sum_reg         <= 7'd0;
            dist_reg        <= '0;
            digits_open_reg <= 1'b1;
            match_reg       <= rfr_pkg::MATCH_ALL;
        end
        else
        begin
            phase_reg       <= phase_next;
            addr_reg        <= addr_next;
            cmd_reg         <= cmd_next;
            pend_reg        <= pend_next;
            body_cnt_reg    <= body_cnt_next;
            sum_reg         <= sum_next;
            dist_reg        <= dist_next;
            digits_open_reg <= digits_open_next;
            match_reg       <= match_next;
        end
    end

    // output register with skid stage
    assign push = frame_done;
    assign pop  = out_valid_reg && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                    skid_valid_reg <= 1'b0;
            end
            else if (push && out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            if (pop || !out_valid_reg)
                out_valid_reg <= skid_valid_reg || push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= res_new;
        end
        if (!skid_valid_reg && push && out_valid_reg && !pop)
            skid_reg <= res_new;
    end

    assign res_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign frame_address = out_reg.addr;
    assign frame_command = out_reg.cmd;
    assign distance_mm   = out_reg.dist_mm;
    assign device_error  = out_reg.dev;
    assign data_length   = out_reg.len;

`ifndef SYNTHESIS
    // skid entry only exists behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // a completed frame always yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> res_valid)
        else $error("completed frame produced no result");

    // a too-short frame returns to hunting without a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_end && !frame_done && !out_valid_reg)
        |=> (!res_valid && phase_reg == rfr_pkg::PH_HUNT))
        else $error("short frame handled wrongly");

    // opening a frame clears the body count and enters the body phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == rfr_pkg::PH_ADDR && rx_byte != start_byte_reg)
        |=> (body_cnt_reg == '0 && phase_reg == rfr_pkg::PH_BODY))
        else $error("frame open did not reset body count");
`endif

endmodule

// ===== test/range_frame_receiver_unit_tb.sv =====
`timescale 1ns / 100ps
// range_frame_receiver_unit_tb: self-checking bench for the range frame receiver
// drives byte requests and marker writes, predicts each frame result, checks them
// depends on rfr_pkg and range_frame_receiver_unit

module range_frame_receiver_unit_tb;

    localparam int DATA_MAX    = 12;
    localparam int DIST_WIDTH  = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES   = 70;

    localparam logic [7:0]  START_RESET = 8'hAA;
    localparam logic [7:0]  END_RESET   = 8'hA8;
    localparam logic [7:0]  ASCII_0     = 8'h30;
    localparam logic [7:0]  ASCII_9     = 8'h39;
    localparam logic [63:0] DIST_LIMIT  = (64'd1 << DIST_WIDTH) - 64'd1;
    localparam logic [47:0] DEV_TEXT [3] = '{"ERR204", "ERR255", "ERR256"};

    // checksum byte choices for a built frame
    localparam int SUM_GOOD     = 0;
    localparam int SUM_HIGH_BIT = 1;
    localparam int SUM_WRONG    = 2;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [23:0] dist_mm;
        logic [1:0]  dev;
        logic [3:0]  len;
    } frame_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    // block ports
    logic        cfg_we    = 1'b0;
    logic        cfg_index = rfr_pkg::CFG_START_BYTE;
    logic [7:0]  cfg_data  = 8'd0;
    logic        rx_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'd0;
    logic        res_stall = 1'b0;
    logic        rx_stall;
    logic        res_valid;
    logic [1:0]  status;
    logic [7:0]  frame_address;
    logic [7:0]  frame_command;
    logic [23:0] distance_mm;
    logic [1:0]  device_error;
    logic [3:0]  data_length;

    range_frame_receiver_unit #(
        .DATA_MAX   (DATA_MAX),
        .DIST_WIDTH (DIST_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .frame_address (frame_address),
        .frame_command (frame_command),
        .distance_mm   (distance_mm),
        .device_error  (device_error),
        .data_length   (data_length)
    );

    // bench bookkeeping
    logic [7:0]    rx_pending [$];
    logic [7:0]    frame_body [$];
    frame_result_t expected_frames [$];
    logic [7:0]    mark_start;
    logic [7:0]    mark_end;
    int            cycle_count    = 0;
    int            mismatch_count = 0;
    int            frames_checked = 0;
    int            bytes_queued   = 0;
    int            bytes_sent     = 0;
    int            settings_used  = 0;
    int            rx_stall_cycles = 0;
    logic          rx_taken  = 1'b0;
    logic          res_taken = 1'b0;

    // parser copy used for prediction
    rfr_pkg::phase_t ps_phase;
    logic [7:0]    ps_addr;
    logic [7:0]    ps_cmd;
    logic [7:0]    ps_pending;
    logic [6:0]    ps_count;
    logic [6:0]    ps_sum;
    logic [31:0]   ps_dist;
    logic          ps_digits;
    logic [2:0]    ps_match;

    task automatic report_error(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // clear the frame registers and latch a new address
    function automatic void open_frame(input logic [7:0] a);
        ps_addr    = a;
        ps_cmd     = 8'd0;
        ps_pending = 8'd0;
        ps_count   = 7'd0;
        ps_sum     = a[6:0];
        ps_dist    = 32'd0;
        ps_digits  = 1'b1;
        ps_match   = 3'b111;
    endfunction

    // fold the held body byte into command, sum, distance and text match
    function automatic void commit_body_byte();
        logic [7:0]  b;
        logic [63:0] v;
        int          idx;
        b      = ps_pending;
        ps_sum = 7'(ps_sum + b[6:0]);
        if (ps_count == 7'd1) begin
            ps_cmd = b;
        end
        else begin
            idx = int'(ps_count) - 2;
            if (ps_digits && b >= ASCII_0 && b <= ASCII_9) begin
                v = {32'd0, ps_dist} * 64'd10 + 64'(b - ASCII_0);
                if (v > DIST_LIMIT)
                    v = DIST_LIMIT;
                ps_dist = v[31:0];
            end
            else begin
                ps_digits = 1'b0;
            end
            for (int c = 0; c < 3; c++) begin
                if (idx >= 6)
                    ps_match[c] = 1'b0;
                else if (DEV_TEXT[c][8*(5-idx) +: 8] != b)
                    ps_match[c] = 1'b0;
            end
        end
    endfunction

    // advance the parser copy by one byte; returns 1 when a frame result is due
    function automatic bit step_parser(input logic [7:0] b, output frame_result_t fr);
        int         n;
        logic [1:0] dev;
        fr = '0;
        step_parser = 1'b0;
        case (ps_phase)
            rfr_pkg::PH_ADDR:
            begin
                if (b != mark_start) begin
                    open_frame(b);
                    ps_phase = rfr_pkg::PH_BODY;
                end
            end
            rfr_pkg::PH_BODY:
            begin
                if (b != mark_end) begin
                    if (ps_count != 7'd0)
                        commit_body_byte();
                    ps_pending = b;
                    if (ps_count < 7'd127)
                        ps_count = ps_count + 7'd1;
                end
                else begin
                    ps_phase = rfr_pkg::PH_HUNT;
                    if (ps_count >= 7'd2) begin
                        n   = int'(ps_count) - 2;
                        dev = rfr_pkg::DEV_NONE;
                        if (n == 6) begin
                            if (ps_match[0])
                                dev = rfr_pkg::DEV_ERR204;
                            else if (ps_match[1])
                                dev = rfr_pkg::DEV_ERR255;
                            else if (ps_match[2])
                                dev = rfr_pkg::DEV_ERR256;
                        end
                        if (n > DATA_MAX)
                            fr.status = rfr_pkg::ST_TOO_LONG;
                        else if (ps_pending != {1'b0, ps_sum})
                            fr.status = rfr_pkg::ST_CHECKSUM;
                        else if (dev != rfr_pkg::DEV_NONE)
                            fr.status = rfr_pkg::ST_DEV_ERR;
                        else
                            fr.status = rfr_pkg::ST_OK;
                        fr.addr    = ps_addr;
                        fr.cmd     = ps_cmd;
                        fr.dist_mm = (dev != rfr_pkg::DEV_NONE) ? 24'd0 : ps_dist[23:0];
                        fr.dev     = dev;
                        fr.len     = (n > 15) ? 4'd15 : 4'(n);
                        step_parser = 1'b1;
                    end
                end
            end
            default:
            begin
                ps_phase = (b == mark_start) ? rfr_pkg::PH_ADDR : rfr_pkg::PH_HUNT;
            end
        endcase
    endfunction

    // monitor: byte acceptance feeds the prediction, result acceptance is checked
    frame_result_t seen_frame;
    frame_result_t want_frame;
    frame_result_t next_frame;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (!rst_n) begin
            rx_taken  <= 1'b0;
            res_taken <= 1'b0;
        end
        else begin
            rx_taken  <= rx_valid && !rx_stall;
            res_taken <= res_valid && !res_stall;
            if (rx_valid && rx_stall)
                rx_stall_cycles++;
            if (res_valid && !res_stall) begin
                seen_frame.status  = status;
                seen_frame.addr    = frame_address;
                seen_frame.cmd     = frame_command;
                seen_frame.dist_mm = distance_mm;
                seen_frame.dev     = device_error;
                seen_frame.len     = data_length;
                frames_checked++;
                if (expected_frames.size() == 0) begin
                    report_error($sformatf("result with no frame pending, address %02h",
                        seen_frame.addr));
                end
                else begin
                    want_frame = expected_frames.pop_front();
                    if (seen_frame.status != want_frame.status)
                        report_error($sformatf("status %0d, want %0d",
                            seen_frame.status, want_frame.status));
                    if (seen_frame.addr != want_frame.addr)
                        report_error($sformatf("frame_address %02h, want %02h",
                            seen_frame.addr, want_frame.addr));
                    if (seen_frame.cmd != want_frame.cmd)
                        report_error($sformatf("frame_command %02h, want %02h",
                            seen_frame.cmd, want_frame.cmd));
                    if (seen_frame.dist_mm != want_frame.dist_mm)
                        report_error($sformatf("distance_mm %0d, want %0d",
                            seen_frame.dist_mm, want_frame.dist_mm));
                    if (seen_frame.dev != want_frame.dev)
                        report_error($sformatf("device_error %0d, want %0d",
                            seen_frame.dev, want_frame.dev));
                    if (seen_frame.len != want_frame.len)
                        report_error($sformatf("data_length %0d, want %0d",
                            seen_frame.len, want_frame.len));
                end
            end
            if (rx_valid && !rx_stall) begin
                if (step_parser(rx_byte, next_frame))
                    expected_frames.push_back(next_frame);
            end
        end
    end

    // byte driver: one request per queued byte, random gap after each
    int rx_gap   = 0;
    bit rx_quiet = 1'b0;

    always @(negedge clk) begin
        if (rst_n && !(rx_valid && !rx_taken)) begin
            if (rx_gap > 0) begin
                rx_valid <= 1'b0;
                rx_gap--;
            end
            else if (rx_pending.size() != 0) begin
                rx_byte  <= rx_pending.pop_front();
                rx_valid <= 1'b1;
                bytes_sent++;
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
                rx_gap = rx_quiet ? 0 : $urandom_range(0, 5);
            end
            else begin
                rx_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stall drawn for every result request
    int res_hold  = 0;
    bit res_quiet = 1'b0;
    bit res_drawn = 1'b0;

    always @(negedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end
        else begin
            if (res_taken)
                res_drawn = 1'b0;
            if (res_valid && !res_drawn) begin
                if ($urandom_range(0, 29) == 0)
                    res_quiet = !res_quiet;
                res_hold  = res_quiet ? 0 : $urandom_range(0, 5);
                res_drawn = 1'b1;
            end
            if (res_hold > 0) begin
                res_stall <= 1'b1;
                res_hold--;
            end
            else begin
                res_stall <= 1'b0;
            end
        end
    end

    // stimulus helpers
    task automatic push_rx(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [7:0] pick_byte(input int lo, input int hi, input logic [7:0] avoid);
        logic [7:0] b;
        do
            b = 8'($urandom_range(lo, hi));
        while (b == avoid);
        return b;
    endfunction

    // start marker(s), address, command, frame_body, checksum, end marker
    task automatic queue_frame(input logic [7:0] a, input logic [7:0] c, input int reps,
                               input int sum_mode);
        logic [6:0] sum;
        logic [7:0] chk;
        sum = 7'(a[6:0] + c[6:0]);
        foreach (frame_body[i])
            sum = 7'(sum + frame_body[i][6:0]);
        case (sum_mode)
            SUM_HIGH_BIT: chk = {1'b1, sum};
            SUM_WRONG:    chk = {1'b0, sum ^ 7'($urandom_range(1, 127))};
            default:      chk = {1'b0, sum};
        endcase
        repeat (reps)
            push_rx(mark_start);
        push_rx(a);
        push_rx(c);
        foreach (frame_body[i])
            push_rx(frame_body[i]);
        push_rx(chk);
        push_rx(mark_end);
    endtask

    // data content of one frame by kind
    task automatic fill_body(input int kind);
        int         n;
        int         txt;
        int         pos;
        logic [7:0] b;
        frame_body.delete();
        txt = $urandom_range(0, 2);
        case (kind)
            0:
            begin
                n = $urandom_range(0, 6);
                repeat (n)
                    frame_body.push_back(pick_byte(ASCII_0, ASCII_9, mark_end));
            end
            1:
            begin
                n = $urandom_range(0, 4);
                repeat (n)
                    frame_body.push_back(pick_byte(ASCII_0, ASCII_9, mark_end));
                n = $urandom_range(1, 5);
                repeat (n)
                    frame_body.push_back(pick_byte(0, 255, mark_end));
            end
            2:
            begin
                n = $urandom_range(0, DATA_MAX);
                repeat (n)
                    frame_body.push_back(pick_byte(0, 255, mark_end));
            end
            3:
            begin
                for (int i = 0; i < 6; i++)
                    frame_body.push_back(DEV_TEXT[txt][8*(5-i) +: 8]);
            end
            4:
            begin
                // near misses of the error texts
                for (int i = 0; i < 6; i++)
                    frame_body.push_back(DEV_TEXT[txt][8*(5-i) +: 8]);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        pos = $urandom_range(0, 5);
                        b   = pick_byte(0, 255, mark_end);
                        frame_body[pos] = b;
                    end
                    1:       frame_body.pop_back();
                    default: frame_body.push_back(pick_byte(0, 255, mark_end));
                endcase
            end
            5:
            begin
                // long digit runs can push the distance into saturation
                n = $urandom_range(7, DATA_MAX);
                repeat (n)
                    frame_body.push_back($urandom_range(0, 1) ? ASCII_9 :
                        pick_byte(ASCII_0, ASCII_9, mark_end));
            end
            default:
            begin
                n = $urandom_range(DATA_MAX + 1, DATA_MAX + 6);
                repeat (n)
                    frame_body.push_back(pick_byte(0, 255, mark_end));
            end
        endcase
    endtask

    // mostly well-formed frames, some noise and broken frames
    task automatic queue_random_traffic(input int budget);
        int stop_at;
        int pick;
        int reps;
        int smode;
        stop_at = bytes_queued + budget;
        while (bytes_queued < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                fill_body(pick % 7);
                reps  = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1;
                smode = ($urandom_range(0, 4) == 0) ? $urandom_range(SUM_HIGH_BIT, SUM_WRONG)
                                                     : SUM_GOOD;
                queue_frame(pick_byte(0, 255, mark_start), pick_byte(0, 255, mark_end),
                    reps, smode);
            end
            else if (pick < 17) begin
                repeat ($urandom_range(1, 6))
                    push_rx(8'($urandom_range(0, 255)));
            end
            else if (pick < 19) begin
                // frame cut off before its end marker
                push_rx(mark_start);
                push_rx(pick_byte(0, 255, mark_start));
                repeat ($urandom_range(0, 4))
                    push_rx(pick_byte(0, 255, mark_end));
            end
            else begin
                // too short to give a result
                push_rx(mark_start);
                push_rx(pick_byte(0, 255, mark_start));
                if ($urandom_range(0, 1))
                    push_rx(pick_byte(0, 255, mark_end));
                push_rx(mark_end);
            end
        end
    endtask

    // wait until every byte is taken and every frame result has come
    task automatic settle(input int extra);
        while (rx_pending.size() != 0 || rx_valid || expected_frames.size() != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    task automatic write_markers(input logic [7:0] s, input logic [7:0] e);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= rfr_pkg::CFG_START_BYTE;
        cfg_data  <= s;
        @(negedge clk);
        cfg_index <= rfr_pkg::CFG_END_BYTE;
        cfg_data  <= e;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mark_start = s;
        mark_end   = e;
        settings_used++;
    endtask

    // run limit
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run limit of %0d cycles reached", CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // main sequence
    initial begin
        mark_start = START_RESET;
        mark_end   = END_RESET;
        ps_phase   = rfr_pkg::PH_HUNT;
        open_frame(8'd0);
        settings_used = 1;

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // repeated start, lowest address, highest command, digits
        frame_body.delete();
        frame_body.push_back(8'h31);
        frame_body.push_back(8'h32);
        queue_frame(8'h00, 8'hFF, 2, SUM_GOOD);
        // end marker taken as address, then a frame with no body
        push_rx(mark_start);
        push_rx(mark_end);
        push_rx(mark_end);
        // start marker inside the body, checksum with bit 7 set
        frame_body.delete();
        queue_frame(8'hFF, mark_start, 1, SUM_HIGH_BIT);
        // only a command before the end marker
        push_rx(mark_start);
        push_rx(8'h55);
        push_rx(8'h12);
        push_rx(mark_end);

        queue_random_traffic(PHASE_BYTES);
        settle(SETTLE_CYCLES);

        write_markers(8'h00, 8'hFF);
        queue_random_traffic(PHASE_BYTES);
        settle(SETTLE_CYCLES);

        // body longer than the counter can hold
        write_markers(8'hFF, 8'h00);
        push_rx(mark_start);
        push_rx(8'h3C);
        repeat (132)
            push_rx(pick_byte(0, 255, mark_end));
        push_rx(mark_end);
        queue_random_traffic(PHASE_BYTES);
        settle(SETTLE_CYCLES);

        write_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_random_traffic(PHASE_BYTES);
        settle(SETTLE_CYCLES + 4);

        $display("sent %0d bytes under %0d marker settings, %0d frame results checked",
            bytes_sent, settings_used, frames_checked);
        $display("byte requests held by rx_stall for %0d cycles", rx_stall_cycles);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("%0d mismatches", mismatch_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
